// ===== rtl/core/pair_gravity_force_core_defines.svh =====
// Assertion macros shared by the pair gravity force core.
`ifndef PAIR_GRAVITY_FORCE_CORE_DEFINES_SVH
`define PAIR_GRAVITY_FORCE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PGF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pair_gravity_force_core: check failed");

// Next-cycle implication, disabled during reset.
`define PGF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pair_gravity_force_core: check failed");

`endif

// ===== rtl/core/pgf_pkg.sv =====
// Types and constants of the pair gravity force core.
`timescale 1ns / 1ps
package pgf_pkg;

  localparam int FRAC_BITS = 16;

  localparam int POS_W   = 32;
  localparam int MASS_W  = 32;
  localparam int DIFF_W  = POS_W + 1;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int ROOT_W  = DIFF_W + 1;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int SREM_W  = ROOT_W + 2;
  localparam int ESUM_W  = ROOT_W + 1;
  localparam int HALF_W  = 35;
  localparam int MUL_W   = 2 * HALF_W;
  localparam int MULP_W  = 2 * MUL_W;
  localparam int MUL_LAT = 2;
  localparam int MM_W    = 2 * MASS_W;
  localparam int PROD_W  = MM_W + DIFF_W;
  localparam int DEN_W   = ROOT_W + 2 * ESUM_W;
  localparam int NUM_W   = PROD_W + 2 * FRAC_BITS;
  localparam int QUO_W   = 64;
  localparam int REM_W   = DEN_W + 1;
  localparam int DIVC_W  = DEN_W + QUO_W;
  localparam int DIV_LAT = QUO_W + 1;
  localparam int OUT_W   = 64;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE    = 2'd0,
    CFG_SOFT    = 2'd1,
    CFG_MIN_DSQ = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    MODE_SOFT   = 1'b0,
    MODE_CUTOFF = 1'b1
  } mode_e;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_a_x;
    logic signed [POS_W-1:0] pos_a_y;
    logic signed [POS_W-1:0] pos_a_z;
    logic [MASS_W-1:0]       mass_a;
    logic signed [POS_W-1:0] pos_b_x;
    logic signed [POS_W-1:0] pos_b_y;
    logic signed [POS_W-1:0] pos_b_z;
    logic [MASS_W-1:0]       mass_b;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] force_x;
    logic signed [OUT_W-1:0] force_y;
    logic signed [OUT_W-1:0] force_z;
    logic [OUT_W-1:0]        dist_sq;
    logic                    accepted;
    logic                    saturated;
  } out_t;

  // Per-item context carried alongside the square root.
  typedef struct packed {
    logic [2:0]              neg;
    logic [2:0][DIFF_W-1:0]  mag;
    logic [MM_W-1:0]         mm;
    logic [OUT_W-1:0]        dsq;
    logic                    dist_sat;
    logic                    acc;
  } side_t;

  // Per-item context carried alongside the dividers.
  typedef struct packed {
    logic [2:0]              neg;
    logic [OUT_W-1:0]        dsq;
    logic                    dist_sat;
    logic                    acc;
    logic                    zero;
  } res_t;

endpackage

// ===== rtl/core/pair_gravity_force_core.sv =====
// Top level of the pipelined pairwise gravity force core.
`timescale 1ns / 1ps
`include "pair_gravity_force_core_defines.svh"
// Usage:
//  - Input channel in_valid_i/in_ready_o/in_i carries one body pair per
//    transaction; output channel out_valid_o/out_ready_i/out_o returns one
//    force result per pair, in order.
//  - Config channel cfg_valid_i/cfg_idx_i/cfg_data_i writes mode (0),
//    softening length (1) and cutoff threshold (2); cfg_ready_o is always
//    high. Write only while no pair is in flight. Other indexes are ignored.
//  - Throughput: one pair per cycle while the output is not stalled. The
//    pipeline has 109 register stages: the 34-stage
//    square root, the 65-stage dividers (an overflow check, then one quotient bit per stage),
//    six multiplier stages, the difference, sum and denominator stages and the
//    output register.
//  - The whole pipeline advances as one; when the output register holds an
//    unaccepted result and out_ready_i is low, every stage holds and
//    in_ready_o drops. Nothing is lost or repeated across a stall.
//  - Reset (rst_ni low, asynchronous) clears all valid bits and sets every
//    config register to zero (softened mode, no softening, zero threshold).
module pair_gravity_force_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pgf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pgf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  pgf_pkg::in_t                   in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output pgf_pkg::out_t                  out_o
);
  import pgf_pkg::*;

  // ---------------- config registers ----------------
  mode_e              mode_q;
  logic [MASS_W-1:0]  soft_q;
  logic [OUT_W-1:0]   min_dsq_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_SOFT;
      soft_q    <= '0;
      min_dsq_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MODE:    mode_q    <= mode_e'(cfg_data_i[0]);
        CFG_SOFT:    soft_q    <= cfg_data_i[MASS_W-1:0];
        CFG_MIN_DSQ: min_dsq_q <= cfg_data_i[OUT_W-1:0];
        default: ;
      endcase
    end
  end

  // Global advance: the output register is empty or being drained.
  logic out_v_q;
  logic en;
  assign en         = !out_v_q || out_ready_i;
  assign in_ready_o = en;

  // ---------------- stage A: separations ----------------
  logic                    a_v_q;
  logic [2:0]              a_neg_q;
  logic [2:0][DIFF_W-1:0]  a_mag_q;
  logic [MASS_W-1:0]       a_ma_q, a_mb_q;
  logic signed [DIFF_W-1:0] diff [3];

  assign diff[0] = DIFF_W'(in_i.pos_b_x) - DIFF_W'(in_i.pos_a_x);
  assign diff[1] = DIFF_W'(in_i.pos_b_y) - DIFF_W'(in_i.pos_a_y);
  assign diff[2] = DIFF_W'(in_i.pos_b_z) - DIFF_W'(in_i.pos_a_z);

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_neg_q[i] <= diff[i][DIFF_W-1];
        a_mag_q[i] <= diff[i][DIFF_W-1] ? DIFF_W'(-diff[i]) : DIFF_W'(diff[i]);
      end
      a_ma_q <= in_i.mass_a;
      a_mb_q <= in_i.mass_b;
    end
  end

  // ---------------- stage B: squares and mass product ----------------
  logic [MULP_W-1:0] sq_p [3];
  logic [MULP_W-1:0] mm_p;

  for (genvar g = 0; g < 3; g++) begin : g_sq
    pgf_mul u_sq (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (MUL_W'(a_mag_q[g])),
      .b_i   (MUL_W'(a_mag_q[g])),
      .p_o   (sq_p[g])
    );
  end

  pgf_mul u_mm (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (MUL_W'(a_ma_q)),
    .b_i   (MUL_W'(a_mb_q)),
    .p_o   (mm_p)
  );

  logic                   b_v_q   [MUL_LAT];
  logic [2:0]             b_neg_q [MUL_LAT];
  logic [2:0][DIFF_W-1:0] b_mag_q [MUL_LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < MUL_LAT; k++) begin
        b_neg_q[k] <= (k == 0) ? a_neg_q : b_neg_q[k-1];
        b_mag_q[k] <= (k == 0) ? a_mag_q : b_mag_q[k-1];
      end
    end
  end

  // ---------------- stage C: squared distance, clamp, cutoff test ----------------
  logic [SQ_W-1:0] s_sum;
  logic            c_v_q;
  logic [SQ_W-1:0] c_s_q;
  side_t           c_side_q;

  assign s_sum = SQ_W'(sq_p[0]) + SQ_W'(sq_p[1]) + SQ_W'(sq_p[2]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_s_q             <= s_sum;
      c_side_q.neg      <= b_neg_q[MUL_LAT-1];
      c_side_q.mag      <= b_mag_q[MUL_LAT-1];
      c_side_q.mm       <= mm_p[MM_W-1:0];
      c_side_q.dist_sat <= |s_sum[SQ_W-1:OUT_W];
      c_side_q.dsq      <= (|s_sum[SQ_W-1:OUT_W]) ? {OUT_W{1'b1}} : s_sum[OUT_W-1:0];
      c_side_q.acc      <= (mode_q == MODE_SOFT) || (s_sum > SQ_W'(min_dsq_q));
    end
  end

  // ---------------- square root ----------------
  logic              s_v;
  logic [ROOT_W-1:0] s_root;
  side_t             s_side;

  pgf_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .v_i    (c_v_q),
    .s_i    (c_s_q),
    .side_i (c_side_q),
    .v_o    (s_v),
    .root_o (s_root),
    .side_o (s_side)
  );

  // ---------------- stage E: denominator base ----------------
  logic              e_v_q;
  logic [ESUM_W-1:0] e_q;
  logic [ROOT_W-1:0] e_root_q;
  side_t             e_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_q      <= ESUM_W'(s_root)
                + ((mode_q == MODE_SOFT) ? ESUM_W'(soft_q) : ESUM_W'(0));
      e_root_q <= s_root;
      e_side_q <= s_side;
    end
  end

  // ---------------- M1: E^2 and numerator products ----------------
  logic [MULP_W-1:0] ee_p;
  logic [MULP_W-1:0] np_p [3];

  pgf_mul u_ee (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (MUL_W'(e_q)),
    .b_i   (MUL_W'(e_q)),
    .p_o   (ee_p)
  );

  for (genvar g = 0; g < 3; g++) begin : g_np
    pgf_mul u_np (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (MUL_W'(e_side_q.mm)),
      .b_i   (MUL_W'(e_side_q.mag[g])),
      .p_o   (np_p[g])
    );
  end

  logic              m1_v_q    [MUL_LAT];
  logic [ROOT_W-1:0] m1_root_q [MUL_LAT];
  side_t             m1_side_q [MUL_LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < MUL_LAT; k++) begin
        m1_root_q[k] <= (k == 0) ? e_root_q : m1_root_q[k-1];
        m1_side_q[k] <= (k == 0) ? e_side_q : m1_side_q[k-1];
      end
    end
  end

  // ---------------- M2: full denominator D*E^2 ----------------
  logic [MULP_W-1:0] den_p;

  pgf_mul u_den (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (ee_p[MUL_W-1:0]),
    .b_i   (MUL_W'(m1_root_q[MUL_LAT-1])),
    .p_o   (den_p)
  );

  logic                    m2_v_q    [MUL_LAT];
  logic [2:0][PROD_W-1:0]  m2_np_q   [MUL_LAT];
  res_t                    m2_side_q [MUL_LAT];
  res_t                    m1_res;

  always_comb begin
    m1_res.neg      = m1_side_q[MUL_LAT-1].neg;
    m1_res.dsq      = m1_side_q[MUL_LAT-1].dsq;
    m1_res.dist_sat = m1_side_q[MUL_LAT-1].dist_sat;
    m1_res.acc      = m1_side_q[MUL_LAT-1].acc;
    m1_res.zero     = (m1_root_q[MUL_LAT-1] == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < MUL_LAT; k++) begin
        if (k == 0) begin
          for (int i = 0; i < 3; i++) m2_np_q[0][i] <= np_p[i][PROD_W-1:0];
        end else begin
          m2_np_q[k] <= m2_np_q[k-1];
        end
        m2_side_q[k] <= (k == 0) ? m1_res : m2_side_q[k-1];
      end
    end
  end

  // ---------------- dividers ----------------
  logic [QUO_W-1:0] quo [3];
  logic             ovf [3];

  for (genvar g = 0; g < 3; g++) begin : g_div
    pgf_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (NUM_W'(m2_np_q[MUL_LAT-1][g]) << (2 * FRAC_BITS)),
      .den_i (den_p[DEN_W-1:0]),
      .q_o   (quo[g]),
      .ovf_o (ovf[g])
    );
  end

  logic d_v_q    [DIV_LAT];
  res_t d_side_q [DIV_LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        d_side_q[k] <= (k == 0) ? m2_side_q[MUL_LAT-1] : d_side_q[k-1];
      end
    end
  end

  // ---------------- valid bits of every stage ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      c_v_q <= 1'b0;
      e_v_q <= 1'b0;
      for (int k = 0; k < MUL_LAT; k++) begin
        b_v_q[k]  <= 1'b0;
        m1_v_q[k] <= 1'b0;
        m2_v_q[k] <= 1'b0;
      end
      for (int k = 0; k < DIV_LAT; k++) d_v_q[k] <= 1'b0;
    end else if (en) begin
      a_v_q <= in_valid_i;
      c_v_q <= b_v_q[MUL_LAT-1];
      e_v_q <= s_v;
      for (int k = 0; k < MUL_LAT; k++) begin
        b_v_q[k]  <= (k == 0) ? a_v_q : b_v_q[k-1];
        m1_v_q[k] <= (k == 0) ? e_v_q : m1_v_q[k-1];
        m2_v_q[k] <= (k == 0) ? m1_v_q[MUL_LAT-1] : m2_v_q[k-1];
      end
      for (int k = 0; k < DIV_LAT; k++) begin
        d_v_q[k] <= (k == 0) ? m2_v_q[MUL_LAT-1] : d_v_q[k-1];
      end
    end
  end

  // ---------------- sign, clamp and output register ----------------
  res_t              fin_side;
  logic [OUT_W-1:0]  frc [3];
  logic              sat_any;

  assign fin_side = d_side_q[DIV_LAT-1];

  always_comb begin
    sat_any = fin_side.dist_sat;
    for (int i = 0; i < 3; i++) begin
      if (!fin_side.acc || fin_side.zero) begin
        frc[i] = '0;
      end else if (fin_side.neg[i]) begin
        // Most negative value is reachable without clamping.
        if (ovf[i] || (quo[i] > {1'b1, {(OUT_W-1){1'b0}}})) begin
          frc[i]  = {1'b1, {(OUT_W-1){1'b0}}};
          sat_any = 1'b1;
        end else begin
          frc[i] = ~quo[i] + OUT_W'(1);
        end
      end else begin
        if (ovf[i] || quo[i][QUO_W-1]) begin
          frc[i]  = {1'b0, {(OUT_W-1){1'b1}}};
          sat_any = 1'b1;
        end else begin
          frc[i] = quo[i];
        end
      end
    end
  end

  out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= d_v_q[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.force_x   <= frc[0];
      out_q.force_y   <= frc[1];
      out_q.force_z   <= frc[2];
      out_q.dist_sq   <= fin_side.dsq;
      out_q.accepted  <= fin_side.acc;
      out_q.saturated <= sat_any;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

  // ---------------- assertions ----------------
  `PGF_ASSERT_IMP(a_reject_zero_force,
      out_valid_o && !out_o.accepted,
      out_o.force_x == '0 && out_o.force_y == '0 && out_o.force_z == '0)
  `PGF_ASSERT_NXT(a_div_ovf_saturates,
      en && d_v_q[DIV_LAT-1] && fin_side.acc && !fin_side.zero && ovf[0],
      out_valid_o && out_o.saturated)
  `PGF_ASSERT_NXT(a_dist_clamp_saturates,
      en && d_v_q[DIV_LAT-1] && fin_side.dist_sat,
      out_valid_o && out_o.saturated && out_o.dist_sq == {OUT_W{1'b1}})

endmodule

// ===== rtl/core/pgf_mul.sv =====
// Two-stage unsigned multiplier built from four half-width partial products.
`timescale 1ns / 1ps
module pgf_mul (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [pgf_pkg::MUL_W-1:0]  a_i,
  input  logic [pgf_pkg::MUL_W-1:0]  b_i,
  output logic [pgf_pkg::MULP_W-1:0] p_o
);
  import pgf_pkg::*;

  logic [MUL_W-1:0]  p_ll_q, p_lh_q, p_hl_q, p_hh_q;
  logic [MULP_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_ll_q <= a_i[HALF_W-1:0] * b_i[HALF_W-1:0];
      p_lh_q <= a_i[HALF_W-1:0] * b_i[MUL_W-1:HALF_W];
      p_hl_q <= a_i[MUL_W-1:HALF_W] * b_i[HALF_W-1:0];
      p_hh_q <= a_i[MUL_W-1:HALF_W] * b_i[MUL_W-1:HALF_W];
      p_q    <= MULP_W'(p_ll_q)
              + ((MULP_W'(p_lh_q) + MULP_W'(p_hl_q)) << HALF_W)
              + (MULP_W'(p_hh_q) << MUL_W);
    end
  end

  assign p_o = p_q;

endmodule

// ===== rtl/core/pgf_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module pgf_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       v_i,
  input  logic [pgf_pkg::SQ_W-1:0]   s_i,
  input  pgf_pkg::side_t             side_i,
  output logic                       v_o,
  output logic [pgf_pkg::ROOT_W-1:0] root_o,
  output pgf_pkg::side_t             side_o
);
  import pgf_pkg::*;

  logic              v_q    [ROOT_W];
  logic [RAD_W-1:0]  rad_q  [ROOT_W];
  logic [SREM_W-1:0] rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  side_t             side_q [ROOT_W];

  logic [RAD_W-1:0]  rad_d  [ROOT_W];
  logic [SREM_W-1:0] rem_d  [ROOT_W];
  logic [ROOT_W-1:0] root_d [ROOT_W];

  always_comb begin
    logic [RAD_W-1:0]    rad_c;
    logic [SREM_W-1:0]   rem_c;
    logic [ROOT_W-1:0]   root_c;
    logic [SREM_W+1:0]   r2;
    logic [SREM_W+1:0]   trial;
    for (int k = 0; k < ROOT_W; k++) begin
      if (k == 0) begin
        rad_c  = RAD_W'(s_i);
        rem_c  = '0;
        root_c = '0;
      end else begin
        rad_c  = rad_q[k-1];
        rem_c  = rem_q[k-1];
        root_c = root_q[k-1];
      end
      r2    = {rem_c, rad_c[RAD_W-1 -: 2]};
      trial = (SREM_W+2)'({root_c, 2'b01});
      if (r2 >= trial) begin
        rem_d[k]  = SREM_W'(r2 - trial);
        root_d[k] = {root_c[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d[k]  = SREM_W'(r2);
        root_d[k] = {root_c[ROOT_W-2:0], 1'b0};
      end
      rad_d[k] = rad_c << 2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ROOT_W; k++) v_q[k] <= 1'b0;
    end else if (en_i) begin
      for (int k = 0; k < ROOT_W; k++) v_q[k] <= (k == 0) ? v_i : v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < ROOT_W; k++) begin
        rad_q[k]  <= rad_d[k];
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        side_q[k] <= (k == 0) ? side_i : side_q[k-1];
      end
    end
  end

  assign v_o    = v_q[ROOT_W-1];
  assign root_o = root_q[ROOT_W-1];
  assign side_o = side_q[ROOT_W-1];

endmodule

// ===== rtl/core/pgf_div.sv =====
// Pipelined restoring divider with a 64-bit quotient and overflow flag.
`timescale 1ns / 1ps
module pgf_div (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [pgf_pkg::NUM_W-1:0] num_i,
  input  logic [pgf_pkg::DEN_W-1:0] den_i,
  output logic [pgf_pkg::QUO_W-1:0] q_o,
  output logic                      ovf_o
);
  import pgf_pkg::*;

  // Stage 0 checks for a quotient of 2^64 or more and loads the upper bits.
  logic [REM_W-1:0] rem_q [DIV_LAT];
  logic [QUO_W-1:0] low_q [DIV_LAT];
  logic [DEN_W-1:0] den_q [DIV_LAT];
  logic [QUO_W-1:0] quo_q [DIV_LAT];
  logic             ovf_q [DIV_LAT];

  logic [REM_W-1:0] rem_d [DIV_LAT];
  logic [QUO_W-1:0] quo_d [DIV_LAT];

  always_comb begin
    logic [REM_W-1:0] r2;
    logic             ge;
    rem_d[0] = REM_W'(num_i >> QUO_W);
    quo_d[0] = '0;
    for (int k = 1; k < DIV_LAT; k++) begin
      r2 = {rem_q[k-1][REM_W-2:0], low_q[k-1][QUO_W-1]};
      ge = (r2 >= REM_W'(den_q[k-1]));
      rem_d[k] = ge ? (r2 - REM_W'(den_q[k-1])) : r2;
      quo_d[k] = {quo_q[k-1][QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= rem_d[0];
      low_q[0] <= num_i[QUO_W-1:0];
      den_q[0] <= den_i;
      quo_q[0] <= quo_d[0];
      ovf_q[0] <= (DIVC_W'(num_i) >= {den_i, {QUO_W{1'b0}}});
      for (int k = 1; k < DIV_LAT; k++) begin
        rem_q[k] <= rem_d[k];
        low_q[k] <= low_q[k-1] << 1;
        den_q[k] <= den_q[k-1];
        quo_q[k] <= quo_d[k];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign q_o   = quo_q[DIV_LAT-1];
  assign ovf_o = ovf_q[DIV_LAT-1];

endmodule

// ===== tb/sv/pair_gravity_force_core_tb.sv =====
// Self-checking testbench for the pairwise gravity force core.
`timescale 1ns / 1ps
module pair_gravity_force_core_tb;
  import pgf_pkg::*;

  localparam int LIMIT_CYC = 400000;   // watchdog limit, far above the worst case
  localparam int LAT_CYC   = 130;      // pipeline depth plus margin
  localparam int N_RAND    = 450;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = CFG_MODE;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  in_t                   in_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_t                  out_o;

  pair_gravity_force_core u_dut (.*);

  always #2 clk_i = ~clk_i;

  // Shadow copy of the config registers
  mode_e       cfg_mode = MODE_SOFT;
  bit [31:0]   cfg_soft = '0;
  bit [63:0]   cfg_min_dsq = '0;

  out_t        force_q[$];
  int          n_err = 0;
  int          n_sent = 0;
  int          n_got = 0;
  int          n_rej = 0;
  int          n_sat = 0;
  int          cyc = 0;
  bit          no_idle = 1'b0;   // back-to-back stretch on both sides

  // Exact force prediction using wide unsigned math.
  function automatic out_t calc_force(in_t p);
    logic signed [32:0] d[3];
    bit [32:0]  ad[3];
    bit [255:0] s, den, num, q;
    bit [33:0]  root, c;
    bit [34:0]  e;
    bit [63:0]  mag;
    bit [63:0]  f[3];
    bit         sat, acc;
    out_t       r;
    d[0] = 33'(p.pos_b_x) - 33'(p.pos_a_x);
    d[1] = 33'(p.pos_b_y) - 33'(p.pos_a_y);
    d[2] = 33'(p.pos_b_z) - 33'(p.pos_a_z);
    s = '0;
    for (int i = 0; i < 3; i++) begin
      ad[i] = d[i] < 0 ? -d[i] : d[i];
      s += 256'(ad[i]) * 256'(ad[i]);
    end
    sat = |s[255:64];
    root = '0;
    for (int b = 33; b >= 0; b--) begin
      c = root | (34'd1 << b);
      if (256'(c) * 256'(c) <= s) root = c;
    end
    if (cfg_mode == MODE_SOFT) begin
      acc = 1'b1;
      e = 35'(root) + 35'(cfg_soft);
    end else begin
      acc = s > 256'(cfg_min_dsq);
      e = 35'(root);
    end
    f = '{default: '0};
    if (acc && root != 0) begin
      den = 256'(root) * 256'(e) * 256'(e);
      for (int i = 0; i < 3; i++) begin
        num = (256'(p.mass_a) * 256'(p.mass_b) * 256'(ad[i])) << (2 * FRAC_BITS);
        q = num / den;
        mag = |q[255:64] ? '1 : q[63:0];
        if (d[i] < 0) begin
          if (mag > 64'h8000_0000_0000_0000) begin
            sat = 1'b1;
            mag = 64'h8000_0000_0000_0000;
          end
          f[i] = -mag;
        end else begin
          if (mag > 64'h7FFF_FFFF_FFFF_FFFF) begin
            sat = 1'b1;
            mag = 64'h7FFF_FFFF_FFFF_FFFF;
          end
          f[i] = mag;
        end
      end
    end
    r.force_x   = f[0];
    r.force_y   = f[1];
    r.force_z   = f[2];
    r.dist_sq   = sat && |s[255:64] ? '1 : s[63:0];
    r.accepted  = acc;
    r.saturated = sat;
    return r;
  endfunction

  // Watchdog
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT_CYC) begin
      $display("Timeout after %0d cycles", cyc);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result scoreboard: every output transaction pops the oldest expectation
  always @(posedge clk_i) begin
    out_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_got++;
      if (force_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("Unexpected result %h", out_o);
      end else begin
        exp_r = force_q.pop_front();
        if (out_o.force_x !== exp_r.force_x || out_o.force_y !== exp_r.force_y ||
            out_o.force_z !== exp_r.force_z || out_o.dist_sq !== exp_r.dist_sq ||
            out_o.accepted !== exp_r.accepted || out_o.saturated !== exp_r.saturated) begin
          n_err++;
          if (n_err <= 10) begin
            $display("Mismatch on result %0d:", n_got);
            $display("  exp f=%h %h %h d=%h acc=%b sat=%b", exp_r.force_x, exp_r.force_y,
                     exp_r.force_z, exp_r.dist_sq, exp_r.accepted, exp_r.saturated);
            $display("  got f=%h %h %h d=%h acc=%b sat=%b", out_o.force_x, out_o.force_y,
                     out_o.force_z, out_o.dist_sq, out_o.accepted, out_o.saturated);
          end
        end
        if (!exp_r.accepted) n_rej++;
        if (exp_r.saturated) n_sat++;
      end
    end
  end

  // Output back-pressure: random stall before each result
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 12);
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // One input transaction; the expectation is queued at the accepting edge
  task automatic send_pair(in_t p, bit typed, out_t typed_r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= p;
    do @(posedge clk_i); while (!in_ready_o);
    force_q.push_back(typed ? typed_r : calc_force(p));
    n_sent++;
  endtask

  // Let the pipeline empty before touching config
  task automatic drain();
    in_valid_i <= 1'b0;
    while (force_q.size() != 0) @(posedge clk_i);
    repeat (LAT_CYC) @(posedge clk_i);
  endtask

  // One config transaction, then the channel is left idle before the task returns
  task automatic write_reg(cfg_idx_e idx, bit [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_MODE:    cfg_mode = mode_e'(val[0]);
      CFG_SOFT:    cfg_soft = val[31:0];
      CFG_MIN_DSQ: cfg_min_dsq = val;
      default:     ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic in_t rand_pair(int kind);
    in_t p;
    p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if (kind < 6) begin
      // nearby bodies with modest masses give meaningful force values
      p.pos_b_x = p.pos_a_x + $signed(32'($urandom_range(0, 32'h60000)) - 32'h30000);
      p.pos_b_y = p.pos_a_y + $signed(32'($urandom_range(0, 32'h60000)) - 32'h30000);
      p.pos_b_z = p.pos_a_z + $signed(32'($urandom_range(0, 32'h60000)) - 32'h30000);
      p.mass_a  = $urandom_range(0, 32'h00FF_FFFF);
      p.mass_b  = $urandom_range(0, 32'h00FF_FFFF);
    end else if (kind == 6) begin
      p.pos_b_x = p.pos_a_x + $signed(32'($urandom_range(0, 4)) - 2);
      p.pos_b_y = p.pos_a_y;
      p.pos_b_z = p.pos_a_z + $signed(32'($urandom_range(0, 2)) - 1);
    end
    return p;
  endfunction

  typedef struct {
    mode_e mode;
    in_t   pair;
    bit    typed;
    out_t  res;
  } dir_row_t;

  localparam logic [31:0] PMAX = 32'h7FFF_FFFF;
  localparam logic [31:0] PMIN = 32'h8000_0000;
  localparam logic [31:0] ONE  = 32'h0001_0000;

  dir_row_t dir_tbl[] = '{
    // zero separation, softened: no force but still accepted
    '{MODE_SOFT, '{ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE}, 1'b1,
      '{64'd0, 64'd0, 64'd0, 64'd0, 1'b1, 1'b0}},
    '{MODE_SOFT, '{PMIN, PMAX, 0, '1, PMIN, PMAX, 0, '1}, 1'b1,
      '{64'd0, 64'd0, 64'd0, 64'd0, 1'b1, 1'b0}},
    // zero masses: force is zero, dist_sq is exact
    '{MODE_SOFT, '{0, 0, 0, 0, ONE, 0, 0, 0}, 1'b1,
      '{64'd0, 64'd0, 64'd0, 64'h1_0000_0000, 1'b1, 1'b0}},
    '{MODE_SOFT, '{0, 0, 0, ONE, ONE, 0, 0, ONE}, 1'b0, '0},
    '{MODE_SOFT, '{0, 0, 0, ONE, 0, -ONE, 0, ONE}, 1'b0, '0},
    '{MODE_SOFT, '{0, 0, 0, ONE, 0, 0, 1, ONE}, 1'b0, '0},
    '{MODE_SOFT, '{0, 0, 0, '1, 0, 0, 1, '1}, 1'b0, '0},
    '{MODE_SOFT, '{0, 0, 0, '1, 0, 1, -1, '1}, 1'b0, '0},
    // opposite corners: squared distance saturates
    '{MODE_SOFT, '{PMIN, PMIN, PMIN, '1, PMAX, PMAX, PMAX, '1}, 1'b0, '0},
    '{MODE_SOFT, '{PMAX, PMAX, PMAX, ONE, PMIN, PMIN, PMIN, ONE}, 1'b0, '0},
    '{MODE_SOFT, '{PMIN, 0, 0, '1, PMAX, 0, 0, '1}, 1'b0, '0},
    '{MODE_SOFT, '{1, 2, 3, 32'h10, 4, 5, 6, 32'h20}, 1'b0, '0},
    // cutoff with zero separation is always rejected
    '{MODE_CUTOFF, '{ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE}, 1'b1,
      '{64'd0, 64'd0, 64'd0, 64'd0, 1'b0, 1'b0}},
    '{MODE_CUTOFF, '{0, 0, 0, ONE, ONE, 0, 0, ONE}, 1'b0, '0},
    '{MODE_CUTOFF, '{0, 0, 0, '1, 0, 0, -1, '1}, 1'b0, '0},
    '{MODE_CUTOFF, '{PMIN, PMIN, PMIN, '1, PMAX, PMAX, PMAX, '1}, 1'b0, '0},
    '{MODE_CUTOFF, '{0, 0, 0, '1, 0, 1, 0, '1}, 1'b0, '0}
  };

  initial begin
    int per_ph;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows; mode switches drain the pipe first
    foreach (dir_tbl[k]) begin
      if (dir_tbl[k].mode != cfg_mode) begin
        drain();
        write_reg(CFG_MODE, 64'(dir_tbl[k].mode));
      end
      send_pair(dir_tbl[k].pair, dir_tbl[k].typed, dir_tbl[k].res);
    end

    // Random phases, each with its own register setting
    per_ph = N_RAND / 7;
    for (int ph = 0; ph < 7; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(CFG_MODE, 64'(MODE_SOFT));
          write_reg(CFG_SOFT, 64'd0);
        end
        1: write_reg(CFG_SOFT, {$urandom, 32'hFFFF_FFFF});   // upper bits dropped
        2: write_reg(CFG_SOFT, 64'($urandom_range(0, 32'h0004_0000)));
        3: begin
          write_reg(CFG_MODE, 64'hFFFF_FFFF_FFFF_FFFE);     // bit 0 only: softened
          write_reg(cfg_idx_e'(3), {$urandom, $urandom});   // unmapped index
          write_reg(CFG_SOFT, 64'($urandom));
        end
        4: begin
          write_reg(CFG_MODE, 64'(MODE_CUTOFF));
          write_reg(CFG_MIN_DSQ, 64'd0);
        end
        5: write_reg(CFG_MIN_DSQ, '1);
        default: write_reg(CFG_MIN_DSQ, 64'($urandom_range(0, 32'h4_0000)) << 16);
      endcase
      no_idle = (ph == 3);
      for (int k = 0; k < per_ph; k++) begin
        // hold off once mid-run until the pipe is empty
        if (ph == 2 && k == per_ph / 2) begin
          in_valid_i <= 1'b0;
          while (force_q.size() != 0) @(posedge clk_i);
        end
        send_pair(rand_pair($urandom_range(0, 9)), 1'b0, '0);
      end
      no_idle = 1'b0;
    end

    in_valid_i <= 1'b0;
    while (force_q.size() != 0) @(posedge clk_i);
    repeat (LAT_CYC) @(posedge clk_i);

    $display("Sent %0d body pairs over 7 register settings, checked %0d results", n_sent,
             n_got);
    $display("Of those, %0d rejected by cutoff and %0d saturated", n_rej, n_sat);
    if (n_err == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", n_err);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
